>>> hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    // action codes on the command port
    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // character codes
    localparam logic [7:0] CH_NUL     = 8'd0;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN  = 8'd13;
    localparam logic [7:0] CH_BLANK   = 8'h20;

    localparam logic [7:0] ATTR_RESET = 8'd112;

    // tab stops every four columns
    localparam int TAB_W = 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_NOP,
        OP_NEWLINE,
        OP_RETURN,
        OP_TAB,
        OP_CHAR,
        OP_CLEAR,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] ch;
        logic [4:0] row;
        logic [6:0] col;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic init_busy;
    } t_back_status;

endpackage

`default_nettype wire

>>> hw/rtl/tcw_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hw/rtl/tcw_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_front
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic         i_start,
    output logic              o_busy,
    input  wire logic [1:0]   i_action,
    input  wire logic [7:0]   i_char_code,
    input  wire logic [4:0]   i_read_row,
    input  wire logic [6:0]   i_read_col,
    input  wire t_q_status    i_q_st,
    input  wire t_back_status i_back_st,
    output logic              o_push,
    output t_cmd              o_cmd
);

    logic in_range;

    assign o_busy   = i_q_st.full | i_back_st.init_busy;
    assign o_push   = i_start & ~o_busy;
    assign in_range = (32'(i_read_row) < ROWS) && (32'(i_read_col) < COLUMNS);

    always_comb begin
        o_cmd.ch  = i_char_code;
        o_cmd.row = i_read_row;
        o_cmd.col = i_read_col;
        unique case (i_action)
            ACT_PUT: begin
                unique case (i_char_code)
                    CH_NUL:     o_cmd.op = OP_NOP;
                    CH_NEWLINE: o_cmd.op = OP_NEWLINE;
                    CH_RETURN:  o_cmd.op = OP_RETURN;
                    CH_TAB:     o_cmd.op = OP_TAB;
                    default:    o_cmd.op = OP_CHAR;
                endcase
            end
            ACT_CLEAR: o_cmd.op = OP_CLEAR;
            // out-of-range reads answer zero without touching the store
            ACT_READ:  o_cmd.op = in_range ? OP_READ : OP_NOP;
            default:   o_cmd.op = OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/tcw_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_queue
    import tcw_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output t_q_status o_st
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_st.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_st.empty = (r_count == '0);
    assign do_push    = i_push & ~o_st.full;
    assign do_pop     = i_pop & ~o_st.empty;
    assign o_cmd      = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/tcw_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_back
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [7:0]  i_attr,
    input  wire t_q_status   i_q_st,
    input  wire t_cmd        i_cmd,
    output logic             o_pop,
    output t_back_status     o_st,
    output logic             o_res_vld,
    output logic [15:0]      o_cell,
    output logic [4:0]       o_row,
    output logic [6:0]       o_col
);

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int CCW   = $clog2(COLUMNS + 1);
    localparam int AW    = RW + CW;
    localparam int DEPTH = ROWS * (2 ** CW);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_FILL,
        S_SCROLL,
        S_SDRAIN,
        S_BLANK,
        S_PUT,
        S_TAB,
        S_READ
    } t_state;

    // what follows the scroll of a line feed
    typedef enum logic [1:0] {
        AFTER_NONE,
        AFTER_CHAR,
        AFTER_TAB
    } t_after;

    t_state          r_state,   n_state;
    logic [RW-1:0]   r_row,     n_row;
    logic [CCW-1:0]  r_col,     n_col;
    logic [RW-1:0]   r_srow,    n_srow;
    logic [CW-1:0]   r_scol,    n_scol;
    t_after          r_after,   n_after;
    logic [7:0]      r_ch,      n_ch;
    logic            r_cp_vld,  n_cp_vld;
    logic [AW-1:0]   r_cp_addr, n_cp_addr;
    logic            r_out_vld, n_out_vld;
    logic [15:0]     r_out_cell, n_out_cell;

    logic            we;
    logic [AW-1:0]   waddr;
    logic [15:0]     wdata;
    logic            re;
    logic [AW-1:0]   raddr;
    logic [15:0]     rdata;

    logic            row_last;
    logic            col_end;
    logic [RW-1:0]   row_inc;
    logic [CCW-1:0]  col_inc;
    logic [RW-1:0]   srow_inc;
    logic            last_scol;
    logic            last_srow;
    logic            last_copy_row;
    logic [15:0]     blank_cell;
    logic            tab_stop;

    assign row_last      = (r_row == RW'(ROWS - 1));
    assign col_end       = (r_col == CCW'(COLUMNS));
    assign row_inc       = r_row + 1'b1;
    assign col_inc       = r_col + 1'b1;
    assign srow_inc      = r_srow + 1'b1;
    assign last_scol     = (r_scol == CW'(COLUMNS - 1));
    assign last_srow     = (r_srow == RW'(ROWS - 1));
    assign last_copy_row = (r_srow == RW'(ROWS - 2));
    assign blank_cell    = {i_attr, CH_BLANK};
    assign tab_stop      = (col_inc[TAB_W-1:0] == '0) || (col_inc == CCW'(COLUMNS));

    always_comb begin
        n_state    = r_state;
        n_row      = r_row;
        n_col      = r_col;
        n_srow     = r_srow;
        n_scol     = r_scol;
        n_after    = r_after;
        n_ch       = r_ch;
        n_cp_vld   = 1'b0;
        n_cp_addr  = r_cp_addr;
        n_out_vld  = 1'b0;
        n_out_cell = '0;
        o_pop      = 1'b0;
        // a pending scroll copy owns the write port
        we         = r_cp_vld;
        waddr      = r_cp_addr;
        wdata      = rdata;
        re         = 1'b0;
        raddr      = {RW'(i_cmd.row), CW'(i_cmd.col)};

        unique case (r_state)
            S_INIT, S_FILL: begin
                we    = 1'b1;
                waddr = {r_srow, r_scol};
                wdata = (r_state == S_INIT) ? {ATTR_RESET, CH_BLANK} : blank_cell;
                if (last_scol) begin
                    n_scol = '0;
                    if (last_srow) begin
                        n_srow  = '0;
                        n_state = S_IDLE;
                        if (r_state == S_FILL) begin
                            n_row     = '0;
                            n_col     = '0;
                            n_out_vld = 1'b1;
                        end
                    end else begin
                        n_srow = srow_inc;
                    end
                end else begin
                    n_scol = r_scol + 1'b1;
                end
            end

            S_IDLE: begin
                if (!i_q_st.empty) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.op)
                        OP_NOP: begin
                            n_out_vld = 1'b1;
                        end
                        OP_RETURN: begin
                            n_col     = '0;
                            n_out_vld = 1'b1;
                        end
                        OP_NEWLINE: begin
                            n_col = '0;
                            if (row_last) begin
                                n_after = AFTER_NONE;
                                n_srow  = '0;
                                n_scol  = '0;
                                n_state = S_SCROLL;
                            end else begin
                                n_row     = row_inc;
                                n_out_vld = 1'b1;
                            end
                        end
                        OP_CHAR: begin
                            if (col_end) begin
                                if (row_last) begin
                                    n_col   = '0;
                                    n_ch    = i_cmd.ch;
                                    n_after = AFTER_CHAR;
                                    n_srow  = '0;
                                    n_scol  = '0;
                                    n_state = S_SCROLL;
                                end else begin
                                    we        = 1'b1;
                                    waddr     = {row_inc, CW'(0)};
                                    wdata     = {i_attr, i_cmd.ch};
                                    n_row     = row_inc;
                                    n_col     = CCW'(1);
                                    n_out_vld = 1'b1;
                                end
                            end else begin
                                we        = 1'b1;
                                waddr     = {r_row, r_col[CW-1:0]};
                                wdata     = {i_attr, i_cmd.ch};
                                n_col     = col_inc;
                                n_out_vld = 1'b1;
                            end
                        end
                        OP_TAB: begin
                            if (col_end) begin
                                n_col = '0;
                                if (row_last) begin
                                    n_after = AFTER_TAB;
                                    n_srow  = '0;
                                    n_scol  = '0;
                                    n_state = S_SCROLL;
                                end else begin
                                    n_row   = row_inc;
                                    n_state = S_TAB;
                                end
                            end else begin
                                n_state = S_TAB;
                            end
                        end
                        OP_CLEAR: begin
                            n_srow  = '0;
                            n_scol  = '0;
                            n_state = S_FILL;
                        end
                        OP_READ: begin
                            re      = 1'b1;
                            n_state = S_READ;
                        end
                    endcase
                end
            end

            // read row below, write it here in the next cycle
            S_SCROLL: begin
                re        = 1'b1;
                raddr     = {srow_inc, r_scol};
                n_cp_vld  = 1'b1;
                n_cp_addr = {r_srow, r_scol};
                if (last_scol) begin
                    n_scol = '0;
                    if (last_copy_row) begin
                        n_state = S_SDRAIN;
                    end else begin
                        n_srow = srow_inc;
                    end
                end else begin
                    n_scol = r_scol + 1'b1;
                end
            end

            S_SDRAIN: begin
                n_scol  = '0;
                n_state = S_BLANK;
            end

            S_BLANK: begin
                we    = 1'b1;
                waddr = {RW'(ROWS - 1), r_scol};
                wdata = blank_cell;
                if (last_scol) begin
                    n_scol = '0;
                    unique case (r_after)
                        AFTER_NONE: begin
                            n_out_vld = 1'b1;
                            n_state   = S_IDLE;
                        end
                        AFTER_CHAR: n_state = S_PUT;
                        AFTER_TAB:  n_state = S_TAB;
                        default:    n_state = S_IDLE;
                    endcase
                end else begin
                    n_scol = r_scol + 1'b1;
                end
            end

            S_PUT: begin
                we        = 1'b1;
                waddr     = {r_row, CW'(0)};
                wdata     = {i_attr, r_ch};
                n_col     = CCW'(1);
                n_out_vld = 1'b1;
                n_state   = S_IDLE;
            end

            S_TAB: begin
                we    = 1'b1;
                waddr = {r_row, r_col[CW-1:0]};
                wdata = blank_cell;
                n_col = col_inc;
                if (tab_stop) begin
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            S_READ: begin
                n_out_vld  = 1'b1;
                n_out_cell = rdata;
                n_state    = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_row     <= '0;
            r_col     <= '0;
            r_srow    <= '0;
            r_scol    <= '0;
            r_after   <= AFTER_NONE;
            r_cp_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_row     <= n_row;
            r_col     <= n_col;
            r_srow    <= n_srow;
            r_scol    <= n_scol;
            r_after   <= n_after;
            r_cp_vld  <= n_cp_vld;
            r_out_vld <= n_out_vld;
        end
        r_ch       <= n_ch;
        r_cp_addr  <= n_cp_addr;
        r_out_cell <= n_out_cell;
    end

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_st.init_busy = (r_state == S_INIT);
    assign o_res_vld      = r_out_vld;
    assign o_cell         = r_out_cell;
    assign o_row          = 5'(r_row);
    assign o_col          = 7'(r_col);

endmodule

`default_nettype wire

>>> hw/rtl/text_console_writer_unit.sv
// items: put, return, newline and ignored items are done straight from idle; an in-range
//   read waits on the ram, a tab writes its pad blanks one by one, clear blanks the whole
//   store, and a newline on the last row scrolls first, as does a character that wraps there
// throughput: one item per cycle while the two-entry command queue has room; the back
//   end's single ram write port sets the rate of tabs, scrolls and clears (one cell a cycle)
// reset: i_rst_n synchronous active low; after it a pass over all cells blanks the
//   store with attribute 112 while busy stays high; results cannot be stalled
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // command beat
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_action,
    input  wire logic [7:0]  i_char_code,
    input  wire logic [4:0]  i_read_row,
    input  wire logic [6:0]  i_read_col,
    // attribute register
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata,
    // result beat, one cycle strobe
    output logic             o_done,
    output logic [15:0]      o_cell_value,
    output logic [4:0]       o_cursor_row,
    output logic [6:0]       o_cursor_col
);

    // attribute byte for every written, blanked or cleared cell
    logic [7:0]   r_attr;

    // front end to queue
    logic         push;
    t_cmd         push_cmd;

    // queue to back end
    t_cmd         head_cmd;
    t_q_status    q_st;
    logic         pop;

    // back end status, holds the front off during the power-up clear
    t_back_status back_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (i_cfg_we) begin
            r_attr <= i_cfg_wdata;
        end
    end

    // accepts the beat and sorts it into a command code
    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_start     (start),
        .o_busy      (busy),
        .i_action    (i_action),
        .i_char_code (i_char_code),
        .i_read_row  (i_read_row),
        .i_read_col  (i_read_col),
        .i_q_st      (q_st),
        .i_back_st   (back_st),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    // short queue so the front keeps taking beats while the back end writes
    tcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_st    (q_st)
    );

    // cursor, screen ram, scroll / clear / tab sequencer and result register
    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_attr    (r_attr),
        .i_q_st    (q_st),
        .i_cmd     (head_cmd),
        .o_pop     (pop),
        .o_st      (back_st),
        .o_res_vld (o_done),
        .o_cell    (o_cell_value),
        .o_row     (o_cursor_row),
        .o_col     (o_cursor_col)
    );

    // a nonzero cell value only rides on a strobed read result
    `ASSERT_IMPLY(a_cell_on_done, i_clk, i_rst_n, o_cell_value != 16'd0, o_done, "stray cell")

    // no result comes out of the power-up clear pass
    `ASSERT_IMPLY(a_no_done_in_init, i_clk, i_rst_n, o_done, !back_st.init_busy, "done in init")

    // an accepted beat is in the queue or being popped next cycle
    `ASSERT_NEXT(a_accept_queued, i_clk, i_rst_n, start && !busy, !q_st.empty, "beat lost")

endmodule

`default_nettype wire

>>> sim/text_console_writer_unit_tb.sv
`timescale 1ns / 1ps

module text_console_writer_unit_tb;
    import tcw_pkg::*;

    // screen geometry of the instance under test
    localparam int COLS        = 80;
    localparam int ROWS_N      = 25;
    localparam int CELLS       = COLS * ROWS_N;
    localparam int TAB_STOP    = 1 << TAB_W;

    // stimulus sizing
    localparam int ITEM_TARGET = 1200;
    localparam int PHASE_LEN   = 200;
    localparam int N_PHASES    = 6;
    localparam int N_DIRECTED  = 22;

    // a clear or scroll walks the whole store before its result comes out, so a
    // long idle stretch is normal; the limit is several times that worst case
    localparam int IDLE_LIMIT  = 20000;

    // the action code the block leaves undefined
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // one result beat: read cell plus cursor after the item
    typedef struct packed {
        logic [15:0] cell_val;
        logic [4:0]  row;
        logic [6:0]  col;
    } t_console_report;

    // one row of the directed table; known marks a typed-in result
    typedef struct packed {
        logic [1:0]      action;
        logic [7:0]      ch;
        logic [4:0]      rr;
        logic [6:0]      rc;
        logic            known;
        t_console_report report;
    } t_directed_cmd;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_action;
    logic [7:0]  i_char_code;
    logic [4:0]  i_read_row;
    logic [6:0]  i_read_col;
    logic        i_cfg_we;
    logic [7:0]  i_cfg_wdata;
    logic        o_done;
    logic [15:0] o_cell_value;
    logic [4:0]  o_cursor_row;
    logic [6:0]  o_cursor_col;

    text_console_writer_unit #(
        .COLUMNS (COLS),
        .ROWS    (ROWS_N)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_char_code  (i_char_code),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_done       (o_done),
        .o_cell_value (o_cell_value),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col)
    );

    // shadow copy of the console: screen store, cursor and attribute
    logic [15:0] screen_image [CELLS];
    int          cur_row;
    int          cur_col;
    logic [7:0]  attr_model;

    // results still owed by the block, oldest first
    t_console_report reports_due [$];

    int mismatch_count;
    int counted_items;
    int gap_max;
    int idle_cycles;

    t_directed_cmd directed_cmds [N_DIRECTED];

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // console shadow model
    // ------------------------------------------------------------------

    function automatic void fill_screen(logic [15:0] v);
        for (int i = 0; i < CELLS; i++) screen_image[i] = v;
    endfunction

    // move to the next row, scrolling everything up at the bottom
    function automatic void start_new_line();
        if (cur_row < ROWS_N - 1) begin
            cur_row++;
        end else begin
            for (int i = 0; i < (ROWS_N - 1) * COLS; i++)
                screen_image[i] = screen_image[i + COLS];
            for (int i = (ROWS_N - 1) * COLS; i < CELLS; i++)
                screen_image[i] = {attr_model, CH_BLANK};
        end
        cur_col = 0;
    endfunction

    // write at the cursor and advance; a pending wrap writes nothing
    function automatic void store_cell(logic [7:0] ch);
        if (cur_col < COLS) begin
            screen_image[cur_row * COLS + cur_col] = {attr_model, ch};
            cur_col++;
        end
    endfunction

    function automatic t_console_report apply_console_action(
        logic [1:0] act, logic [7:0] ch, logic [4:0] rr, logic [6:0] rc);
        t_console_report rep;
        int              pad;
        rep.cell_val = '0;
        case (act)
            ACT_PUT: begin
                if (ch == CH_NEWLINE) begin
                    start_new_line();
                end else if (ch == CH_RETURN) begin
                    cur_col = 0;
                end else if (ch == CH_TAB) begin
                    // a tab on a pending wrap takes the new line first
                    if (cur_col >= COLS) start_new_line();
                    pad = TAB_STOP - (cur_col % TAB_STOP);
                    while (pad != 0 && cur_col < COLS) begin
                        store_cell(CH_BLANK);
                        pad--;
                    end
                end else if (ch != CH_NUL) begin
                    if (cur_col >= COLS) start_new_line();
                    store_cell(ch);
                end
            end
            ACT_CLEAR: begin
                fill_screen({attr_model, CH_BLANK});
                cur_row = 0;
                cur_col = 0;
            end
            ACT_READ: begin
                // out of range reads give zero
                if (int'(rr) < ROWS_N && int'(rc) < COLS)
                    rep.cell_val = screen_image[int'(rr) * COLS + int'(rc)];
            end
            default: begin
            end
        endcase
        rep.row = 5'(cur_row);
        rep.col = 7'(cur_col);
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // command side
    // ------------------------------------------------------------------

    // drive one command beat after a random hold-off; at the accepting edge
    // the shadow model steps and the owed result is queued. start is left
    // high so a back-to-back beat does not drop it between beats
    task automatic issue_item(input logic [1:0] act, input logic [7:0] ch,
                              input logic [4:0] rr, input logic [6:0] rc,
                              input logic known, input t_console_report known_rep);
        int              gap;
        t_console_report predicted;
        gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_action    <= act;
        i_char_code <= ch;
        i_read_row  <= rr;
        i_read_col  <= rc;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        predicted = apply_console_action(act, ch, rr, rc);
        reports_due.push_back(known ? known_rep : predicted);
        // ignored items do not count toward the stimulus size
        if (!(act == ACT_UNUSED || (act == ACT_PUT && ch == CH_NUL)))
            counted_items++;
    endtask

    task automatic send(input logic [1:0] act, input logic [7:0] ch,
                        input logic [4:0] rr, input logic [6:0] rc);
        issue_item(act, ch, rr, rc, 1'b0, '0);
    endtask

    // attribute writes only once the block has gone quiet
    task automatic write_attribute(input logic [7:0] v);
        start <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        attr_model = v;
        i_cfg_we   <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    function automatic void flag_mismatch(string what, t_console_report want,
                                          t_console_report got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s: expected cell %h row %0d col %0d, got cell %h row %0d col %0d",
                     what, want.cell_val, want.row, want.col,
                     got.cell_val, got.row, got.col);
    endfunction

    // every strobed beat is taken at the edge that ends its cycle
    always @(posedge i_clk) begin : report_check
        t_console_report want;
        t_console_report got;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            got = '{o_cell_value, o_cursor_row, o_cursor_col};
            if (reports_due.size() == 0) begin
                flag_mismatch("result beat with nothing owed", '0, got);
            end else begin
                want = reports_due.pop_front();
                if (got.cell_val !== want.cell_val || got.row !== want.row
                    || got.col !== want.col)
                    flag_mismatch("result beat mismatch", want, got);
            end
        end
    end

    // hang detection: cycles in which no beat moves on either side
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_done === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    initial begin
        int         kind;
        int         n;
        int         pick;
        int         phase;
        int         next_phase_at;
        logic [7:0] ch;
        logic [4:0] rr;
        logic [6:0] rc;
        logic [7:0] attr_plan [N_PHASES];

        // every input known from time zero
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_action       = ACT_PUT;
        i_char_code    = CH_NUL;
        i_read_row     = '0;
        i_read_col     = '0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        mismatch_count = 0;
        counted_items  = 0;
        idle_cycles    = 0;
        gap_max        = 9;

        attr_model = ATTR_RESET;
        cur_row    = 0;
        cur_col    = 0;
        fill_screen({ATTR_RESET, CH_BLANK});

        // extremes first, a random one in the middle, back to reset last
        attr_plan = '{8'h00, 8'hFF, 8'h1F, 8'h00, 8'hC3, ATTR_RESET};
        attr_plan[3] = 8'($urandom_range(255, 0));

        // known results assume attribute 112 right after reset
        directed_cmds = '{
            // fresh store reads blank at both corners
            '{ACT_READ,   CH_NUL,     5'd0,  7'd0,   1'b1, '{16'h7020, 5'd0, 7'd0}},
            '{ACT_READ,   CH_NUL,     5'd24, 7'd79,  1'b1, '{16'h7020, 5'd0, 7'd0}},
            // reads past the row, the column, and at all-ones
            '{ACT_READ,   CH_NUL,     5'd25, 7'd0,   1'b1, '{16'h0000, 5'd0, 7'd0}},
            '{ACT_READ,   CH_NUL,     5'd0,  7'd80,  1'b1, '{16'h0000, 5'd0, 7'd0}},
            '{ACT_READ,   8'hFF,      5'd31, 7'd127, 1'b1, '{16'h0000, 5'd0, 7'd0}},
            // unused action does nothing
            '{ACT_UNUSED, 8'hFF,      5'd31, 7'd127, 1'b1, '{16'h0000, 5'd0, 7'd0}},
            '{ACT_PUT,    8'h41,      5'd0,  7'd0,   1'b1, '{16'h0000, 5'd0, 7'd1}},
            // null byte is dropped
            '{ACT_PUT,    CH_NUL,     5'd31, 7'd127, 1'b1, '{16'h0000, 5'd0, 7'd1}},
            '{ACT_PUT,    8'hFF,      5'd0,  7'd0,   1'b1, '{16'h0000, 5'd0, 7'd2}},
            '{ACT_READ,   CH_NUL,     5'd0,  7'd1,   1'b1, '{16'h70FF, 5'd0, 7'd2}},
            // tab pads two blanks up to the stop
            '{ACT_PUT,    CH_TAB,     5'd0,  7'd0,   1'b1, '{16'h0000, 5'd0, 7'd4}},
            '{ACT_READ,   CH_NUL,     5'd0,  7'd3,   1'b1, '{16'h7020, 5'd0, 7'd4}},
            '{ACT_PUT,    CH_RETURN,  5'd0,  7'd0,   1'b1, '{16'h0000, 5'd0, 7'd0}},
            '{ACT_PUT,    CH_NEWLINE, 5'd0,  7'd0,   1'b1, '{16'h0000, 5'd1, 7'd0}},
            '{ACT_PUT,    CH_TAB,     5'd0,  7'd0,   1'b0, '0},
            '{ACT_PUT,    8'h80,      5'd0,  7'd0,   1'b0, '0},
            '{ACT_READ,   CH_NUL,     5'd0,  7'd0,   1'b0, '0},
            '{ACT_READ,   CH_NUL,     5'd1,  7'd4,   1'b0, '0},
            // clear homes the cursor and blanks the store
            '{ACT_CLEAR,  CH_NUL,     5'd0,  7'd0,   1'b1, '{16'h0000, 5'd0, 7'd0}},
            '{ACT_READ,   CH_NUL,     5'd0,  7'd0,   1'b1, '{16'h7020, 5'd0, 7'd0}},
            '{ACT_PUT,    8'h7F,      5'd0,  7'd0,   1'b0, '0},
            '{ACT_READ,   CH_NUL,     5'd0,  7'd0,   1'b0, '0}
        };

        // reset, then let the power-up blanking pass finish
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);

        // directed table
        for (int i = 0; i < N_DIRECTED; i++)
            issue_item(directed_cmds[i].action, directed_cmds[i].ch,
                       directed_cmds[i].rr, directed_cmds[i].rc,
                       directed_cmds[i].known, directed_cmds[i].report);

        // random bursts, with the attribute changed every phase
        phase         = 0;
        next_phase_at = 0;
        while (counted_items < ITEM_TARGET) begin
            if (counted_items >= next_phase_at && phase < N_PHASES) begin
                write_attribute(attr_plan[phase]);
                phase++;
                next_phase_at += PHASE_LEN;
            end

            // about a quarter of the bursts run with no hold-off at all
            gap_max = ($urandom_range(3, 0) == 0) ? 0 : 9;
            kind    = $urandom_range(99, 0);

            if (kind < 38) begin
                // running text with the odd control byte
                n = $urandom_range(120, 1);
                repeat (n) begin
                    pick = $urandom_range(99, 0);
                    if (pick < 3)       ch = CH_NEWLINE;
                    else if (pick < 7)  ch = CH_RETURN;
                    else if (pick < 13) ch = CH_TAB;
                    else if (pick < 15) ch = CH_NUL;
                    else                ch = 8'($urandom_range(255, 0));
                    send(ACT_PUT, ch, 5'($urandom_range(31, 0)),
                         7'($urandom_range(127, 0)));
                end
            end else if (kind < 55) begin
                // cell reads, a few out of range
                n = $urandom_range(20, 1);
                repeat (n) begin
                    rr = ($urandom_range(9, 0) == 0) ? 5'($urandom_range(31, ROWS_N))
                                                     : 5'($urandom_range(ROWS_N - 1, 0));
                    rc = ($urandom_range(9, 0) == 0) ? 7'($urandom_range(127, COLS))
                                                     : 7'($urandom_range(COLS - 1, 0));
                    send(ACT_READ, 8'($urandom_range(255, 0)), rr, rc);
                end
            end else if (kind < 63) begin
                // fill the line to the pending-wrap column, then poke it
                while (cur_col < COLS)
                    send(ACT_PUT, 8'($urandom_range(255, 14)),
                         5'($urandom_range(31, 0)), 7'($urandom_range(127, 0)));
                case ($urandom_range(4, 0))
                    0:       send(ACT_PUT, CH_TAB, '0, '0);
                    1:       send(ACT_PUT, 8'($urandom_range(255, 14)), '0, '0);
                    2:       send(ACT_PUT, CH_NEWLINE, '0, '0);
                    3:       send(ACT_PUT, CH_RETURN, '0, '0);
                    default: send(ACT_READ, CH_NUL, 5'(cur_row), 7'(COLS - 1));
                endcase
            end else if (kind < 69) begin
                // newline runs reach the bottom row and scroll
                n = $urandom_range(30, 1);
                repeat (n) send(ACT_PUT, CH_NEWLINE, '0, '0);
            end else if (kind < 76) begin
                // tab runs cross the right edge
                n = $urandom_range(24, 1);
                repeat (n) begin
                    if ($urandom_range(4, 0) != 0) send(ACT_PUT, CH_TAB, '0, '0);
                    else send(ACT_PUT, 8'($urandom_range(255, 14)), '0, '0);
                end
            end else if (kind < 80) begin
                send(ACT_CLEAR, 8'($urandom_range(255, 0)), 5'($urandom_range(31, 0)),
                     7'($urandom_range(127, 0)));
            end else if (kind < 88) begin
                // ignored beats: unused action or null byte
                n = $urandom_range(5, 1);
                repeat (n) begin
                    if ($urandom_range(1, 0) == 0)
                        send(ACT_UNUSED, 8'($urandom_range(255, 0)),
                             5'($urandom_range(31, 0)), 7'($urandom_range(127, 0)));
                    else
                        send(ACT_PUT, CH_NUL, 5'($urandom_range(31, 0)),
                             7'($urandom_range(127, 0)));
                end
            end else begin
                // fully random beats
                n = $urandom_range(10, 1);
                repeat (n)
                    send(2'($urandom_range(3, 0)), 8'($urandom_range(255, 0)),
                         5'($urandom_range(31, 0)), 7'($urandom_range(127, 0)));
            end
        end

        // drain, then watch a little longer for stray result beats
        start <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
